### rtl/wasc_pkg.sv
// Shared widths, register codes and the per-bin state type of the windowed
// above-sum counter. Used by every module under rtl; depends on nothing.
package wasc_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int MAX_BINS    = 64;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 24;
  localparam int CNT_W       = 16;
  localparam int BOUND_W     = 16;
  localparam int WLEN_W      = 9;
  localparam int BCNT_W      = 7;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int STORE_AW    = SLOT_W + BIN_W;
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_BINS;
  localparam int FRAC_W      = 12;
  localparam int PROD_W      = BOUND_W + 1 + SUM_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_W       = BIN_W + CNT_W + SUM_W;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUND         = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_BIN_COUNT     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [CNT_W-1:0] cnt;
  } bin_state_t;

endpackage

### rtl/wasc_sample_store.sv
// Window sample store: one sample per (slot, bin), registered read with
// write-to-read forwarding and a zero sweep after reset. Uses wasc_pkg.
module wasc_sample_store (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 rd_en,
  input  logic [wasc_pkg::STORE_AW-1:0]        rd_addr,
  input  logic                                 wr_en,
  input  logic [wasc_pkg::STORE_AW-1:0]        wr_addr,
  input  logic signed [wasc_pkg::SAMPLE_W-1:0] wr_data,
  output logic signed [wasc_pkg::SAMPLE_W-1:0] rd_data,
  output logic                                 busy
);

  logic signed [wasc_pkg::SAMPLE_W-1:0] mem_r [wasc_pkg::STORE_DEPTH];
  logic signed [wasc_pkg::SAMPLE_W-1:0] rd_q_r;
  logic signed [wasc_pkg::SAMPLE_W-1:0] fwd_r;
  logic                                 hit_r;
  logic                                 clearing_r;
  logic [wasc_pkg::STORE_AW-1:0]        clr_addr_r;
  logic                                 mem_we;
  logic [wasc_pkg::STORE_AW-1:0]        mem_waddr;
  logic signed [wasc_pkg::SAMPLE_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == wasc_pkg::STORE_AW'(wasc_pkg::STORE_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing_r || wr_en;
  assign mem_waddr = clearing_r ? clr_addr_r : wr_addr;
  assign mem_wdata = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
      // a write in the same cycle to the same entry wins over the array
      hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_r  <= wr_data;
    end
  end

  assign rd_data = hit_r ? fwd_r : rd_q_r;
  assign busy    = clearing_r;

endmodule

### rtl/wasc_bin_table.sv
// Per-bin running sum and counter table, registered read with forwarding of
// the write that lands on the same bin, zero sweep after reset. Uses wasc_pkg.
module wasc_bin_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [wasc_pkg::BIN_W-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [wasc_pkg::BIN_W-1:0]    wr_addr,
  input  wasc_pkg::bin_state_t          wr_data,
  output wasc_pkg::bin_state_t          rd_data,
  output logic                          busy
);

  wasc_pkg::bin_state_t         mem_r [wasc_pkg::MAX_BINS];
  wasc_pkg::bin_state_t         rd_q_r;
  wasc_pkg::bin_state_t         fwd_r;
  logic                         hit_r;
  logic                         clearing_r;
  logic [wasc_pkg::BIN_W-1:0]   clr_addr_r;
  logic                         mem_we;
  logic [wasc_pkg::BIN_W-1:0]   mem_waddr;
  wasc_pkg::bin_state_t         mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == wasc_pkg::BIN_W'(wasc_pkg::MAX_BINS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing_r || wr_en;
  assign mem_waddr = clearing_r ? clr_addr_r : wr_addr;
  assign mem_wdata = clearing_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
      hit_r  <= wr_en && (wr_addr == rd_addr);
      fwd_r  <= wr_data;
    end
  end

  assign rd_data = hit_r ? fwd_r : rd_q_r;
  assign busy    = clearing_r;

endmodule

### rtl/wasc_update.sv
// Per-sample update: retire the leaving sample, refresh the saturated sum,
// score the new sample against bound times the new sum. Uses wasc_pkg.
module wasc_update (
  input  logic [wasc_pkg::BOUND_W-1:0]         bound,
  input  logic signed [wasc_pkg::SAMPLE_W-1:0] x,
  input  logic signed [wasc_pkg::SAMPLE_W-1:0] old,
  input  wasc_pkg::bin_state_t                 cur,
  output wasc_pkg::bin_state_t                 nxt
);

  localparam int WIDE_W = wasc_pkg::SUM_W + 2;
  localparam int PAD_W  = wasc_pkg::PROD_W - wasc_pkg::SAMPLE_W - wasc_pkg::FRAC_W;

  logic signed [wasc_pkg::PROD_W-1:0] old_scaled;
  logic signed [wasc_pkg::PROD_W-1:0] x_scaled;
  logic signed [wasc_pkg::PROD_W-1:0] lim_old;
  logic signed [wasc_pkg::PROD_W-1:0] lim_new;
  logic signed [WIDE_W-1:0]           sum_wide;
  logic signed [wasc_pkg::SUM_W-1:0]  sum_sat;
  logic signed [wasc_pkg::CNT_W-1:0]  cnt_dec;
  logic signed [wasc_pkg::CNT_W-1:0]  cnt_inc;
  logic signed [wasc_pkg::CNT_W-1:0]  cnt_min;
  logic signed [wasc_pkg::CNT_W-1:0]  cnt_max;
  logic                               old_above;
  logic                               new_above;
  logic                               sum_ovf;

  assign cnt_min = {1'b1, {(wasc_pkg::CNT_W-1){1'b0}}};
  assign cnt_max = {1'b0, {(wasc_pkg::CNT_W-1){1'b1}}};

  assign old_scaled = {{PAD_W{old[wasc_pkg::SAMPLE_W-1]}}, old, {wasc_pkg::FRAC_W{1'b0}}};
  assign x_scaled   = {{PAD_W{x[wasc_pkg::SAMPLE_W-1]}}, x, {wasc_pkg::FRAC_W{1'b0}}};

  assign lim_old   = $signed({1'b0, bound}) * cur.sum;
  assign old_above = old_scaled > lim_old;

  assign sum_wide = WIDE_W'(cur.sum) - WIDE_W'(old) + WIDE_W'(x);
  // top three bits disagree: out of the 24-bit range, clamp by sign
  assign sum_ovf  = !((sum_wide[WIDE_W-1:wasc_pkg::SUM_W-1] == '0) ||
                      (sum_wide[WIDE_W-1:wasc_pkg::SUM_W-1] == '1));
  assign sum_sat  = !sum_ovf ? sum_wide[wasc_pkg::SUM_W-1:0] :
                    sum_wide[WIDE_W-1] ? {1'b1, {(wasc_pkg::SUM_W-1){1'b0}}} :
                                         {1'b0, {(wasc_pkg::SUM_W-1){1'b1}}};

  assign lim_new   = $signed({1'b0, bound}) * sum_sat;
  assign new_above = x_scaled > lim_new;

  assign cnt_dec = (old_above && (cur.cnt != cnt_min)) ? cur.cnt - 1'b1 : cur.cnt;
  assign cnt_inc = (new_above && (cnt_dec != cnt_max)) ? cnt_dec + 1'b1 : cnt_dec;

  assign nxt = {sum_sat, cnt_inc};

endmodule

### rtl/windowed_above_sum_counter.sv
// Windowed above-sum counter: takes one signed bin sample per cycle and
// returns one result per sample with the bin's updated window sum and
// saturating above-count. Sustained rate is one sample per clock, set by the
// single read-modify-write of the sample store and bin table per sample;
// a sample passes the s1 stage register and then the output register before
// out_tvalid rises for its result. A stalled output with a sample staged
// behind it holds in_tready low. After reset the sample store is swept to
// zero, one entry per cycle, and in_tready stays low until the sweep ends;
// configuration writes are taken throughout.
module windowed_above_sum_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [15:0] sample
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wasc_pkg::SAMPLE_W-1:0]     in_tdata,
  // out_tdata: [5:0] bin_index, [21:6] above_count, [45:22] window_sum, zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wasc_pkg::OUT_BYTES_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wasc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wasc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [wasc_pkg::BOUND_W-1:0]         bound_r;
  logic [wasc_pkg::WLEN_W-1:0]          wlen_r;
  logic [wasc_pkg::BCNT_W-1:0]          bcnt_r;
  logic [wasc_pkg::WLEN_W-1:0]          wlen_eff;
  logic [wasc_pkg::BCNT_W-1:0]          bcnt_eff;

  logic [wasc_pkg::BIN_W-1:0]           bin_pos_r;
  logic [wasc_pkg::SLOT_W-1:0]          slot_pos_r;
  logic [wasc_pkg::WLEN_W-1:0]          slot_inc;
  logic                                 acc_last;
  logic                                 accept;

  logic                                 s1_valid_r;
  logic signed [wasc_pkg::SAMPLE_W-1:0] s1_x_r;
  logic [wasc_pkg::BIN_W-1:0]           s1_bin_r;
  logic [wasc_pkg::SLOT_W-1:0]          s1_slot_r;
  logic                                 s1_last_r;
  logic                                 s1_adv;

  logic                                 out_valid_r;
  logic [wasc_pkg::BIN_W-1:0]           out_bin_r;
  wasc_pkg::bin_state_t                 out_state_r;
  logic                                 out_last_r;

  logic signed [wasc_pkg::SAMPLE_W-1:0] old_sample;
  wasc_pkg::bin_state_t                 cur_state;
  wasc_pkg::bin_state_t                 new_state;
  logic                                 store_busy;
  logic                                 table_busy;
  logic                                 busy;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= wasc_pkg::BOUND_W'(4096);
      wlen_r  <= wasc_pkg::WLEN_W'(16);
      bcnt_r  <= wasc_pkg::BCNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wasc_pkg::REG_BOUND:         bound_r <= cfg_data[wasc_pkg::BOUND_W-1:0];
        wasc_pkg::REG_WINDOW_LENGTH: wlen_r  <= cfg_data[wasc_pkg::WLEN_W-1:0];
        wasc_pkg::REG_BIN_COUNT:     bcnt_r  <= cfg_data[wasc_pkg::BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign wlen_eff = (wlen_r == '0) ? wasc_pkg::WLEN_W'(1) :
                    (wlen_r > wasc_pkg::WLEN_W'(wasc_pkg::MAX_WINDOW)) ?
                    wasc_pkg::WLEN_W'(wasc_pkg::MAX_WINDOW) : wlen_r;
  assign bcnt_eff = (bcnt_r == '0) ? wasc_pkg::BCNT_W'(1) :
                    (bcnt_r > wasc_pkg::BCNT_W'(wasc_pkg::MAX_BINS)) ?
                    wasc_pkg::BCNT_W'(wasc_pkg::MAX_BINS) : bcnt_r;

  // handshake and pipeline control
  assign busy      = store_busy || table_busy;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !busy && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  assign acc_last = (wasc_pkg::BCNT_W'(bin_pos_r) + 1'b1) >= bcnt_eff;
  assign slot_inc = wasc_pkg::WLEN_W'(slot_pos_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_pos_r  <= '0;
      slot_pos_r <= '0;
    end else if (accept) begin
      if (acc_last) begin
        bin_pos_r  <= '0;
        slot_pos_r <= (slot_inc >= wlen_eff) ? '0 : slot_inc[wasc_pkg::SLOT_W-1:0];
      end else begin
        bin_pos_r  <= bin_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r    <= $signed(in_tdata);
      s1_bin_r  <= bin_pos_r;
      s1_slot_r <= slot_pos_r;
      s1_last_r <= acc_last;
    end
  end

  // state reads go out on the transfer edge, writes when the item retires
  wasc_sample_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr ({slot_pos_r, bin_pos_r}),
    .wr_en   (s1_adv),
    .wr_addr ({s1_slot_r, s1_bin_r}),
    .wr_data (s1_x_r),
    .rd_data (old_sample),
    .busy    (store_busy)
  );

  wasc_bin_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (bin_pos_r),
    .wr_en   (s1_adv),
    .wr_addr (s1_bin_r),
    .wr_data (new_state),
    .rd_data (cur_state),
    .busy    (table_busy)
  );

  wasc_update u_update (
    .bound (bound_r),
    .x     (s1_x_r),
    .old   (old_sample),
    .cur   (cur_state),
    .nxt   (new_state)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bin_r   <= s1_bin_r;
      out_state_r <= new_state;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = wasc_pkg::OUT_BYTES_W'({out_state_r.sum, out_state_r.cnt, out_bin_r});

  // no sample may enter while either store is still being swept
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept)
    else $error("sample transferred during clearing sweep");

  // a full pipeline with a stalled output must hold off the input
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline is full and stalled");

  // the last bin of a frame restarts the bin position
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && acc_last) |=> (bin_pos_r == '0) && s1_last_r)
    else $error("bin position did not wrap at frame end");

  // a staged item always reaches the output register on the next edge it advances
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r && (out_last_r == $past(s1_last_r)))
    else $error("staged result lost on its way to the output");

endmodule

### verif/tb_windowed_above_sum_counter.sv
// Self-checking testbench for windowed_above_sum_counter: streams signed bin samples,
// predicts each bin's window sum and saturating above-count, and checks every result.
// Depends on rtl/wasc_pkg.sv, rtl/windowed_above_sum_counter.sv and its submodules.
module tb_windowed_above_sum_counter;

  localparam int SETTLE      = 8;
  // the limit must outlast the reset sweep, which holds in_tready low
  localparam int STALL_LIMIT = 60000;
  localparam int PHASE_ITEMS = 240;
  localparam logic [wasc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint CNT_HI = (longint'(1) << (wasc_pkg::CNT_W - 1)) - 1;
  localparam longint CNT_LO = -(longint'(1) << (wasc_pkg::CNT_W - 1));
  localparam longint SUM_HI = (longint'(1) << (wasc_pkg::SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (wasc_pkg::SUM_W - 1));
  localparam logic signed [wasc_pkg::SAMPLE_W-1:0] SAMPLE_TOP =
    {1'b0, {(wasc_pkg::SAMPLE_W - 1){1'b1}}};

  typedef struct packed {
    logic [wasc_pkg::BIN_W-1:0]        bin_index;
    logic signed [wasc_pkg::CNT_W-1:0] above_count;
    logic signed [wasc_pkg::SUM_W-1:0] window_sum;
    logic                              frame_end;
  } bin_update_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [wasc_pkg::SAMPLE_W-1:0]        in_tdata = '0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [wasc_pkg::OUT_BYTES_W-1:0]     out_tdata;
  logic                                 out_tlast;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [wasc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [wasc_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  windowed_above_sum_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted block state
  logic [wasc_pkg::BOUND_W-1:0]         bound_q;
  logic [wasc_pkg::WLEN_W-1:0]          win_len_q;
  logic [wasc_pkg::BCNT_W-1:0]          bins_q;
  logic signed [wasc_pkg::SAMPLE_W-1:0] history [wasc_pkg::STORE_DEPTH];
  logic signed [wasc_pkg::SUM_W-1:0]    win_sum [wasc_pkg::MAX_BINS];
  logic signed [wasc_pkg::CNT_W-1:0]    above_cnt [wasc_pkg::MAX_BINS];
  int unsigned                          slot_pos;
  int unsigned                          bin_pos;

  logic signed [wasc_pkg::SAMPLE_W-1:0] samples_to_send [$];
  bin_update_t                          bin_updates_due [$];

  int  send_gap_pct = 0;
  int  recv_stall_pct = 0;
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int  errors = 0;
  int  n_samples = 0;
  int  n_results = 0;
  int  n_writes = 0;
  int  quiet_cycles = 0;

  function automatic longint clip_count(input longint v);
    if (v > CNT_HI) return CNT_HI;
    if (v < CNT_LO) return CNT_LO;
    return v;
  endfunction

  function automatic bit beats_bound(input longint v, input longint total);
    return v * (longint'(1) << wasc_pkg::FRAC_W) > longint'(bound_q) * total;
  endfunction

  function automatic bin_update_t update_bin(
    input logic signed [wasc_pkg::SAMPLE_W-1:0] x);
    int unsigned wl, bc, b, s, slot_idx;
    longint      leaving, total, cnt;
    bin_update_t r;
    wl = (win_len_q == 0) ? 1 :
         ((win_len_q > wasc_pkg::MAX_WINDOW) ? wasc_pkg::MAX_WINDOW : win_len_q);
    bc = (bins_q == 0) ? 1 : ((bins_q > wasc_pkg::MAX_BINS) ? wasc_pkg::MAX_BINS : bins_q);
    b = bin_pos % wasc_pkg::MAX_BINS;
    s = slot_pos % wasc_pkg::MAX_WINDOW;
    slot_idx = s * wasc_pkg::MAX_BINS + b;
    leaving = history[slot_idx];
    total = win_sum[b];
    cnt = above_cnt[b];
    // leaving sample is judged against the sum before the update
    if (beats_bound(leaving, total)) cnt = clip_count(cnt - 1);
    total = total - leaving + x;
    if (total > SUM_HI) total = SUM_HI;
    else if (total < SUM_LO) total = SUM_LO;
    history[slot_idx] = x;
    if (beats_bound(x, total)) cnt = clip_count(cnt + 1);
    above_cnt[b] = cnt[wasc_pkg::CNT_W-1:0];
    win_sum[b] = total[wasc_pkg::SUM_W-1:0];
    r.bin_index = b[wasc_pkg::BIN_W-1:0];
    r.above_count = cnt[wasc_pkg::CNT_W-1:0];
    r.window_sum = total[wasc_pkg::SUM_W-1:0];
    r.frame_end = (b + 1 >= bc);
    if (r.frame_end) begin
      bin_pos = 0;
      slot_pos = (s + 1 >= wl) ? 0 : s + 1;
    end else begin
      bin_pos = b + 1;
    end
    return r;
  endfunction

  // sample driver: advance only after a transfer or while idle
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= samples_to_send.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    bin_update_t want;
    bin_update_t due;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wasc_pkg::REG_BOUND:         bound_q   <= cfg_data[wasc_pkg::BOUND_W-1:0];
          wasc_pkg::REG_WINDOW_LENGTH: win_len_q <= cfg_data[wasc_pkg::WLEN_W-1:0];
          wasc_pkg::REG_BIN_COUNT:     bins_q    <= cfg_data[wasc_pkg::BCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        due = update_bin(in_tdata);
        bin_updates_due = {bin_updates_due, due};
        n_samples++;
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (bin_updates_due.size() == 0) begin
          $error("result transfer with no sample outstanding");
          errors++;
        end else begin
          want = bin_updates_due.pop_front();
          if (out_tdata[wasc_pkg::BIN_W-1:0] !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index,
                   out_tdata[wasc_pkg::BIN_W-1:0]);
            errors++;
          end
          if (out_tdata[wasc_pkg::BIN_W +: wasc_pkg::CNT_W] !== want.above_count) begin
            $error("above_count: expected %0d, got %0d", want.above_count,
                   $signed(out_tdata[wasc_pkg::BIN_W +: wasc_pkg::CNT_W]));
            errors++;
          end
          if (out_tdata[wasc_pkg::BIN_W + wasc_pkg::CNT_W +: wasc_pkg::SUM_W] !==
              want.window_sum) begin
            $error("window_sum: expected %0d, got %0d", want.window_sum,
                   $signed(out_tdata[wasc_pkg::BIN_W + wasc_pkg::CNT_W +: wasc_pkg::SUM_W]));
            errors++;
          end
          if (out_tlast !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_tlast);
            errors++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (++quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", STALL_LIMIT);
      $display("[windowed_above_sum_counter] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (samples_to_send.size() != 0 || in_tvalid || bin_updates_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [wasc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wasc_pkg::CFG_DATA_W-1:0] data);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
    n_writes++;
  endtask

  initial begin : stimulus
    logic signed [wasc_pkg::SAMPLE_W-1:0] s;
    logic [wasc_pkg::CFG_DATA_W-1:0]      bound_w, wlen_w, bcnt_w;
    int                                   p, i;

    bound_q = 16'd4096;
    win_len_q = 9'd16;
    bins_q = 7'd64;
    foreach (history[j]) history[j] = '0;
    foreach (win_sum[j]) begin
      win_sum[j] = '0;
      above_cnt[j] = '0;
    end
    slot_pos = 0;
    bin_pos = 0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // spare index must leave every register alone
    write_reg(REG_SPARE, '1);
    samples_to_send = {16'sh0000, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001,
                       16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
    // bin position 10 is now past the bin count: next sample closes the frame
    write_reg(wasc_pkg::REG_BIN_COUNT, 16'd4);
    samples_to_send = {16'sh0100, 16'sh0200, 16'shFF00, 16'sh0010, 16'sh7FFF, 16'sh8001};
    // slot 2 is past the new window length: used once, then wraps to 0
    write_reg(wasc_pkg::REG_WINDOW_LENGTH, 16'd2);
    samples_to_send = {16'sh0040, 16'shFFC0, 16'sh7FFF, 16'sh8000,
                       16'sh0003, 16'sh0000, 16'sh1234, 16'shEDCB};

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin bound_w = 16'd0;    wlen_w = 16'd1;   bcnt_w = 16'd64;  end
        1: begin bound_w = 16'hFFFF; wlen_w = 16'd256; bcnt_w = 16'd1;   end
        2: begin bound_w = 16'd4096; wlen_w = 16'd0;   bcnt_w = 16'd0;   end
        3: begin
          bound_w = 16'($urandom_range(1, 8192));
          wlen_w  = 16'd300;
          bcnt_w  = 16'd127;
        end
        default: begin
          bound_w = 16'($urandom);
          wlen_w  = 16'($urandom_range(1, 20));
          bcnt_w  = 16'($urandom_range(1, 64));
        end
      endcase
      write_reg(wasc_pkg::REG_BOUND, bound_w);
      write_reg(wasc_pkg::REG_WINDOW_LENGTH, wlen_w);
      write_reg(wasc_pkg::REG_BIN_COUNT, bcnt_w);
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 68; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 68; end
        default: begin send_gap_pct = 9; recv_stall_pct = 9; end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // hold the sender once until every result is back
        if (p == 2 && i == PHASE_ITEMS / 2) wait_drained();
        case ($urandom_range(7))
          0:       s = {1'b1, {(wasc_pkg::SAMPLE_W - 1){1'b0}}};
          1:       s = SAMPLE_TOP;
          2, 3:    s = wasc_pkg::SAMPLE_W'($urandom);
          default: s = wasc_pkg::SAMPLE_W'($urandom_range(400) - 200);
        endcase
        samples_to_send = {samples_to_send, s};
      end
    end

    wait_drained();
    $display("checked %0d results for %0d samples across %0d register writes",
             n_results, n_samples, n_writes);
    $display("phases covered full rate, sender gaps, receiver stalls and clamped settings");
    if (errors == 0) begin
      $display("[windowed_above_sum_counter] OK");
    end else begin
      $display("[windowed_above_sum_counter] ERROR");
    end
    $finish;
  end

endmodule
